// ----- hdl/tmaf_pkg.sv -----
// ----------------------------------------------------------------------------
// tmaf_pkg
// shared defaults and control bundles for the trimmed mean filter
// ----------------------------------------------------------------------------
package tmaf_pkg;

  localparam int WINDOW_DEF       = 10;
  localparam int SAMPLE_WIDTH_DEF = 12;
  localparam int FIRST_KEPT_DEF   = 3;
  localparam int END_KEPT_DEF     = 6;

  // per-cycle command to every cell of the sort chain
  typedef struct packed {
    logic load;   // insert a new sample at its ranked place
    logic drain;  // shift all cells one place toward cell 0
  } cell_ctl_t;

  // command to the mean unit
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic add;    // add the tap value
    logic mul;    // register sum times reciprocal
  } mean_ctl_t;

endpackage

// ----- hdl/tmaf_cell.sv -----
// ----------------------------------------------------------------------------
// tmaf_cell
// one place of the ordered window: insertion on load, shift-down on drain
// ----------------------------------------------------------------------------
module tmaf_cell
  import tmaf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    occupied,
  input  logic                    left_shift,
  input  logic [SAMPLE_WIDTH-1:0] left_val,
  input  logic [SAMPLE_WIDTH-1:0] right_val,
  output logic                    shift_o,
  output logic [SAMPLE_WIDTH-1:0] val_o
);

  logic [SAMPLE_WIDTH-1:0] val_r;
  logic [SAMPLE_WIDTH-1:0] val_nxt;

  // this entry moves up one place when it holds a larger value
  assign shift_o = occupied && (val_r > sample);
  assign val_o   = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.load) begin
      // empty places past the fill point may take junk, never read
      if (!occupied || shift_o) begin
        val_nxt = left_shift ? left_val : sample;
      end
    end else if (ctl.drain) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- hdl/tmaf_mean.sv -----
// ----------------------------------------------------------------------------
// tmaf_mean
// accumulates the kept samples and divides by their count via reciprocal
// ----------------------------------------------------------------------------
module tmaf_mean
  import tmaf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int WINDOW       = WINDOW_DEF,
  parameter int KDIV         = 3
) (
  input  logic                    clk,
  input  mean_ctl_t               ctl,
  input  logic [SAMPLE_WIDTH-1:0] tap_val,
  output logic [SAMPLE_WIDTH-1:0] avg_o
);

  localparam int ACC_W  = SAMPLE_WIDTH + $clog2(WINDOW + 1);
  localparam int SHIFT  = ACC_W + $clog2(KDIV);
  localparam int MUL_W  = SHIFT + 1;
  localparam int PROD_W = ACC_W + MUL_W;
  // floor(2^SHIFT / KDIV) + 1 gives an exact quotient for any ACC_W-bit sum
  localparam longint unsigned MUL_L = ((longint'(1) << SHIFT) / KDIV) + 1;
  localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL_L);

  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [PROD_W-1:0] prod_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = acc_r + ACC_W'(tap_val);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.mul) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(MUL_C);
    end
  end

  assign avg_o = prod_r[SHIFT +: SAMPLE_WIDTH];

endmodule

// ----- hdl/trimmed_mean_adc_filter_unit.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_adc_filter_unit
// ordered window of samples, emits the truncated mean of the middle ranks
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while a window fills (insertion chain)
// after the last sample of a window, the result word is formed by a drain
//   through the tap cell, then the reciprocal multiply and the emit state
// no samples are taken during that drain, multiply and emit, longer while
//   the previous result word is still waiting
// reset: synchronous active-low, empties the window and drops any result
module trimmed_mean_adc_filter_unit
  import tmaf_pkg::*;
#(
  parameter int WINDOW       = WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FIRST_KEPT   = FIRST_KEPT_DEF,
  parameter int END_KEPT     = END_KEPT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,   // sample
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata   // average
);

  localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int END_EFF = (END_KEPT > WINDOW) ? WINDOW : END_KEPT;
  localparam int KEPT    = (END_EFF > FIRST_KEPT) ? (END_EFF - FIRST_KEPT) : 0;
  localparam int KDIV    = (KEPT == 0) ? 1 : KEPT;
  localparam int TAP     = (FIRST_KEPT < WINDOW) ? FIRST_KEPT : 0;
  localparam int FILL_W  = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);

  typedef enum logic [3:0] {
    ST_COLLECT = 4'b0001,
    ST_DRAIN   = 4'b0010,
    ST_MULT    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r;

  logic                    in_fire;
  logic                    last_sample;
  logic [SAMPLE_WIDTH-1:0] sample;
  cell_ctl_t               cell_ctl;
  mean_ctl_t               mean_ctl;
  logic [SAMPLE_WIDTH-1:0] avg;

  logic [WINDOW-1:0]       shift_w;
  logic [SAMPLE_WIDTH-1:0] val_w [WINDOW];

  assign sample      = in_tdata[SAMPLE_WIDTH-1:0];
  assign in_tready   = (state_r == ST_COLLECT);
  assign in_fire     = in_tvalid && in_tready;
  assign last_sample = (fill_r == FILL_W'(WINDOW - 1));

  assign cell_ctl.load  = in_fire;
  assign cell_ctl.drain = (state_r == ST_DRAIN);

  assign mean_ctl.clear = in_fire && last_sample;
  assign mean_ctl.add   = (state_r == ST_DRAIN);
  assign mean_ctl.mul   = (state_r == ST_MULT);

  // insertion chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic                    occ;
    logic                    lsh;
    logic [SAMPLE_WIDTH-1:0] lval;
    logic [SAMPLE_WIDTH-1:0] rval;

    assign occ = (fill_r > FILL_W'(i));
    if (i == 0) begin : g_first
      assign lsh  = 1'b0;
      assign lval = '0;
    end else begin : g_inner
      assign lsh  = shift_w[i-1];
      assign lval = val_w[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign rval = val_w[i];
    end else begin : g_notlast
      assign rval = val_w[i+1];
    end

    tmaf_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .sample    (sample),
      .occupied  (occ),
      .left_shift(lsh),
      .left_val  (lval),
      .right_val (rval),
      .shift_o   (shift_w[i]),
      .val_o     (val_w[i])
    );
  end

  tmaf_mean #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .WINDOW      (WINDOW),
    .KDIV        (KDIV)
  ) u_mean (
    .clk    (clk),
    .ctl    (mean_ctl),
    .tap_val(val_w[TAP]),
    .avg_o  (avg)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_COLLECT: begin
        if (in_fire) begin
          if (last_sample) begin
            fill_nxt = '0;
            cnt_nxt  = CNT_W'(KEPT);
            // empty kept range: sum stays zero
            state_nxt = (KEPT == 0) ? ST_MULT : ST_DRAIN;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || out_tready)) begin
      out_data_r <= avg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

endmodule

// ----- test/trimmed_mean_adc_filter_unit_checker.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_adc_filter_unit_checker
// Watches the sample and average streams of the trimmed mean filter. It keeps
// its own sorted window of the accepted samples. On every tenth sample it
// queues the truncated mean of the middle ranks, then compares each average
// word against the oldest queued value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trimmed_mean_adc_filter_unit_checker
  import tmaf_pkg::*;
#(
  parameter int DW = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [DW-1:0] in_tdata,   // sample
  input  logic          out_tvalid,
  input  logic          out_tready,
  input  logic [DW-1:0] out_tdata,  // average
  output int            fail_count,
  output int            avg_pending
);

  localparam logic [SAMPLE_WIDTH_DEF-1:0] SAMPLE_MASK = '1;

  logic [SAMPLE_WIDTH_DEF-1:0] ranked [WINDOW_DEF];
  logic [SAMPLE_WIDTH_DEF-1:0] avg_q [$];
  logic [SAMPLE_WIDTH_DEF-1:0] new_sample;
  logic [SAMPLE_WIDTH_DEF-1:0] got_avg;
  logic [SAMPLE_WIDTH_DEF-1:0] want_avg;
  int                          held;
  int                          slot;

  // mean of the kept ranks of a full window, truncating
  function automatic logic [SAMPLE_WIDTH_DEF-1:0] middle_mean();
    int stop_rank;
    int sum;
    stop_rank = (END_KEPT_DEF > WINDOW_DEF) ? WINDOW_DEF : END_KEPT_DEF;
    sum = 0;
    if (FIRST_KEPT_DEF >= stop_rank) return '0;
    for (int r = FIRST_KEPT_DEF; r < stop_rank; r++) sum += ranked[r];
    return SAMPLE_WIDTH_DEF'(sum / (stop_rank - FIRST_KEPT_DEF)) & SAMPLE_MASK;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  initial begin
    fail_count  = 0;
    avg_pending = 0;
    held        = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      avg_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        new_sample = in_tdata[SAMPLE_WIDTH_DEF-1:0];
        // equal samples stay ahead of the new word
        slot = held;
        while (slot > 0 && ranked[slot-1] > new_sample) begin
          ranked[slot] = ranked[slot-1];
          slot--;
        end
        ranked[slot] = new_sample;
        held++;
        if (held == WINDOW_DEF) begin
          avg_q.push_back(middle_mean());
          held = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        got_avg = out_tdata[SAMPLE_WIDTH_DEF-1:0];
        if (avg_q.size() == 0) begin
          flag_error($sformatf("average word %0d with no window completed", got_avg));
        end else begin
          want_avg = avg_q.pop_front();
          if (got_avg !== want_avg)
            flag_error($sformatf("average mismatch: expected %0d, got %0d",
                                 want_avg, got_avg));
        end
      end
    end
    avg_pending = avg_q.size();
  end

endmodule

// ----- test/trimmed_mean_adc_filter_unit_test.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_adc_filter_unit_test
// Drives ADC samples into the trimmed mean filter: two directed windows with
// extremes and ties, then random windows of varied shape. Both stream sides
// stall at random. The checker module predicts and compares the averages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trimmed_mean_adc_filter_unit_test;
  import tmaf_pkg::*;

  localparam int DW          = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int RAND_WINDOWS = 163;
  localparam int STALL_LIMIT = 2000;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [DW-1:0] in_tdata;   // sample
  logic          out_tvalid;
  logic          out_tready;
  logic [DW-1:0] out_tdata;  // average
  logic          no_idle;
  int            fail_count;
  int            avg_pending;
  int            stall_cnt;

  // extremes, ties at both ends, then a window of all-max samples
  logic [SW-1:0] directed_samples [20] = '{
    12'd4095, 12'd0, 12'd4095, 12'd0, 12'd2048, 12'd2048, 12'd1, 12'd4094,
    12'd4095, 12'd0,
    12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd4095, 12'd4095, 12'd4095
  };

  trimmed_mean_adc_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  trimmed_mean_adc_filter_unit_checker #(.DW(DW)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .avg_pending (avg_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic push_sample(input logic [SW-1:0] s);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DW'(s);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    int            shape;
    int            step;
    bit            rising;
    logic [SW-1:0] base;
    logic [SW-1:0] s;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    no_idle    = 1'b0;
    stall_cnt  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_samples[i]) push_sample(directed_samples[i]);

    for (int w = 0; w < RAND_WINDOWS; w++) begin
      no_idle = (w >= 60 && w < 90);
      // let every pending average drain before the next window
      if (w % 25 == 12) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (avg_pending != 0) @(negedge clk);
      end
      shape  = $urandom_range(0, 4);
      base   = SW'($urandom_range(0, 4095));
      step   = $urandom_range(0, 455);
      rising = 1'($urandom_range(0, 1));
      for (int k = 0; k < WINDOW_DEF; k++) begin
        case (shape)
          0: s = SW'($urandom_range(0, 4095));
          // tight cluster, lots of ties
          1: s = (base > 12'd4080 ? 12'd4080 : base) + SW'($urandom_range(0, 15));
          2: s = ($urandom_range(0, 3) == 0) ? SW'($urandom_range(0, 4095)) : base;
          // rising or falling ramp, which can wrap at the sample width
          3: s = base + SW'((rising ? k : WINDOW_DEF - 1 - k) * step);
          default: s = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        endcase
        push_sample(s);
      end
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (avg_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && avg_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tmaf_pkg.sv
hdl/tmaf_cell.sv
hdl/tmaf_mean.sv
hdl/trimmed_mean_adc_filter_unit.sv
test/trimmed_mean_adc_filter_unit_checker.sv
test/trimmed_mean_adc_filter_unit_test.sv
